[rtl/ptfl_pkg.sv]
// shared types, constants and microcode program for the thermal frequency limiter
`default_nettype none

package ptfl_pkg;

  // fixed-point and sizing constants
  localparam int unsigned INTEGRAL_WIDTH = 48;
  localparam int unsigned GAIN_FRAC_BITS = 16;

  localparam int unsigned TEMP_W     = 8;
  localparam int unsigned FREQ_W     = 16;
  localparam int unsigned GAIN_W     = 32;
  localparam int unsigned POLL_W     = 16;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  localparam int unsigned MUL_W     = GAIN_W;
  localparam int unsigned PROD_W    = 2 * MUL_W;
  localparam int unsigned ERR_W     = 64;
  localparam int unsigned SCALE_W   = GAIN_W + POLL_W;
  localparam int unsigned DIV_W     = TEMP_W + GAIN_FRAC_BITS;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_W);
  localparam int unsigned ACC_W     = 2 * GAIN_FRAC_BITS + 48;
  localparam int unsigned CAP_LOG2  = 40;
  localparam int unsigned MAG_W     = CAP_LOG2 + 1;
  localparam int unsigned TGT_W     = CAP_LOG2 + 3;

  // register map
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TARGET_TEMP  = 3'd0,
    REG_GAIN_PROP    = 3'd1,
    REG_GAIN_INTEG   = 3'd2,
    REG_GAIN_DERIV   = 3'd3,
    REG_GAIN_OUTPUT  = 3'd4,
    REG_POLL_PERIOD  = 3'd5,
    REG_FREQ_FLOOR   = 3'd6,
    REG_FREQ_CEILING = 3'd7
  } cfg_reg_e;

  typedef struct packed {
    logic        [TEMP_W-1:0] target_temp;
    logic signed [GAIN_W-1:0] gain_prop;
    logic signed [GAIN_W-1:0] gain_integ;
    logic signed [GAIN_W-1:0] gain_deriv;
    logic signed [GAIN_W-1:0] gain_output;
    logic        [POLL_W-1:0] poll_period;
    logic        [FREQ_W-1:0] freq_floor;
    logic        [FREQ_W-1:0] freq_ceiling;
  } cfg_t;

  typedef struct packed {
    logic [FREQ_W-1:0] new_freq;
    logic              hit_ceiling;
    logic              hit_floor;
    logic              overheat_alert;
  } res_t;

  // datapath operations
  typedef enum logic [2:0] {
    OP_NOP      = 3'd0,
    OP_DIV_STEP = 3'd1,
    OP_INTEG    = 3'd2,
    OP_ERR_P    = 3'd3,
    OP_ERR_D    = 3'd4,
    OP_ERR_I    = 3'd5,
    OP_SCALE    = 3'd6
  } dp_op_e;

  // multiplier operand pairs
  typedef enum logic [3:0] {
    MUL_NONE   = 4'd0,
    MUL_P_DLY  = 4'd1,
    MUL_P_KP   = 4'd2,
    MUL_DQ_KD  = 4'd3,
    MUL_I0_KI  = 4'd4,
    MUL_I1_KI  = 4'd5,
    MUL_KO_DLY = 4'd6,
    MUL_E0_S0  = 4'd7,
    MUL_E0_S1  = 4'd8,
    MUL_E1_S0  = 4'd9,
    MUL_E1_S1  = 4'd10
  } mul_sel_e;

  typedef enum logic [1:0] {
    ACC_HOLD   = 2'd0,
    ACC_LOAD   = 2'd1,
    ACC_ADD_32 = 2'd2,
    ACC_ADD_64 = 2'd3
  } acc_op_e;

  typedef enum logic [1:0] {
    JMP_NEXT = 2'd0,
    JMP_LOOP = 2'd1,
    JMP_END  = 2'd2
  } jmp_e;

  typedef struct packed {
    dp_op_e   op;
    mul_sel_e mul;
    acc_op_e  acc;
  } ctl_t;

  localparam int unsigned UPC_W = 4;

  typedef struct packed {
    ctl_t             ctl;
    jmp_e             jmp;
    logic [UPC_W-1:0] tgt;
  } ucode_t;

  typedef struct packed {
    logic busy;
    logic done;
  } seq_stat_t;

  localparam ctl_t CTL_NOP = '{op: OP_NOP, mul: MUL_NONE, acc: ACC_HOLD};

  localparam logic [UPC_W-1:0] UPC_DIV = 4'd0;
  localparam logic [UPC_W-1:0] UPC_END = 4'd13;

  function automatic ucode_t uw(dp_op_e op, mul_sel_e mul, acc_op_e acc, jmp_e jmp);
    ucode_t w;
    w.ctl.op  = op;
    w.ctl.mul = mul;
    w.ctl.acc = acc;
    w.jmp     = jmp;
    w.tgt     = UPC_DIV;
    return w;
  endfunction

  // microcode: divider loop, integral, error terms, then output scaling
  function automatic ucode_t ucode_rom(logic [UPC_W-1:0] upc);
    ucode_t w;
    unique case (upc)
      4'd0:    w = uw(OP_DIV_STEP, MUL_P_DLY,  ACC_HOLD,   JMP_LOOP);
      4'd1:    w = uw(OP_INTEG,    MUL_P_KP,   ACC_HOLD,   JMP_NEXT);
      4'd2:    w = uw(OP_ERR_P,    MUL_DQ_KD,  ACC_HOLD,   JMP_NEXT);
      4'd3:    w = uw(OP_ERR_D,    MUL_KO_DLY, ACC_HOLD,   JMP_NEXT);
      4'd4:    w = uw(OP_SCALE,    MUL_I0_KI,  ACC_HOLD,   JMP_NEXT);
      4'd5:    w = uw(OP_NOP,      MUL_I1_KI,  ACC_LOAD,   JMP_NEXT);
      4'd6:    w = uw(OP_NOP,      MUL_NONE,   ACC_ADD_32, JMP_NEXT);
      4'd7:    w = uw(OP_ERR_I,    MUL_NONE,   ACC_HOLD,   JMP_NEXT);
      4'd8:    w = uw(OP_NOP,      MUL_E0_S0,  ACC_HOLD,   JMP_NEXT);
      4'd9:    w = uw(OP_NOP,      MUL_E0_S1,  ACC_LOAD,   JMP_NEXT);
      4'd10:   w = uw(OP_NOP,      MUL_E1_S0,  ACC_ADD_32, JMP_NEXT);
      4'd11:   w = uw(OP_NOP,      MUL_E1_S1,  ACC_ADD_32, JMP_NEXT);
      4'd12:   w = uw(OP_NOP,      MUL_NONE,   ACC_ADD_64, JMP_NEXT);
      default: w = uw(OP_NOP,      MUL_NONE,   ACC_HOLD,   JMP_END);
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

[rtl/ptfl_seq.sv]
// microcode sequencer: step counter, loop counter and program rom
`default_nettype none

module ptfl_seq (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic                hold_i,
  output ptfl_pkg::ctl_t      ctl_o,
  output ptfl_pkg::seq_stat_t stat_o
);
  import ptfl_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_RUN  = 2'b10
  } seq_state_e;

  seq_state_e             state_q, state_d;
  logic [UPC_W-1:0]       upc_q, upc_d;
  logic [DIV_CNT_W-1:0]   cnt_q, cnt_d;
  ucode_t                 word;
  logic                   running;
  logic                   end_wait;

  assign word     = ucode_rom(upc_q);
  assign running  = (state_q == S_RUN);
  assign end_wait = (word.jmp == JMP_END) && hold_i;

  assign ctl_o       = (running && !end_wait) ? word.ctl : CTL_NOP;
  assign stat_o.busy = running;
  assign stat_o.done = running && (word.jmp == JMP_END) && !hold_i;

  always_comb begin
    state_d = state_q;
    upc_d   = upc_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          state_d = S_RUN;
          upc_d   = UPC_DIV;
          cnt_d   = DIV_CNT_W'(DIV_W - 1);
        end
      end
      S_RUN: begin
        unique case (word.jmp)
          JMP_NEXT: upc_d = upc_q + UPC_W'(1);
          JMP_LOOP: begin
            if (cnt_q != '0) begin
              cnt_d = cnt_q - DIV_CNT_W'(1);
              upc_d = word.tgt;
            end else begin
              upc_d = upc_q + UPC_W'(1);
            end
          end
          JMP_END: begin
            if (!hold_i) begin
              state_d = S_IDLE;
              upc_d   = UPC_DIV;
            end
          end
          default: upc_d = upc_q;
        endcase
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      upc_q   <= UPC_DIV;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      upc_q   <= upc_d;
      cnt_q   <= cnt_d;
    end
  end

`ifndef SYNTH
  a_upc_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    running |-> (upc_q <= UPC_END))
    else $error("step counter beyond program end");
`endif

endmodule

`default_nettype wire

[rtl/ptfl_dp.sv]
// datapath: divider, shared multiplier, accumulator, error and clamp logic
`default_nettype none

module ptfl_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  ptfl_pkg::cfg_t                cfg_i,
  input  logic                          start_i,
  input  logic [ptfl_pkg::TEMP_W-1:0]   temperature_i,
  input  logic [ptfl_pkg::FREQ_W-1:0]   current_freq_i,
  input  ptfl_pkg::ctl_t                ctl_i,
  output ptfl_pkg::res_t                res_o
);
  import ptfl_pkg::*;

  localparam int unsigned IW     = INTEGRAL_WIDTH;
  localparam int unsigned F      = GAIN_FRAC_BITS;
  localparam int unsigned WIDE_W = 2 * PROD_W;
  localparam int unsigned HI_W   = ACC_W - 2 * F;
  localparam int unsigned ADD_W  = TEMP_W + POLL_W;
  localparam logic [IW-1:0]    IMAX    = {1'b0, {(IW - 1){1'b1}}};
  localparam logic [HI_W-1:0]  CAP     = HI_W'(1) << CAP_LOG2;
  localparam logic [ERR_W-1:0] S64_MAX = {1'b0, {(ERR_W - 1){1'b1}}};
  localparam logic [ERR_W-1:0] S64_MIN = {1'b1, {(ERR_W - 1){1'b0}}};

  function automatic logic [GAIN_W-1:0] gain_mag(logic [GAIN_W-1:0] g);
    return g[GAIN_W-1] ? (~g + 1'b1) : g;
  endfunction

  function automatic logic [ERR_W-1:0] apply_sign(logic neg, logic [ERR_W-1:0] m);
    return neg ? (~m + 1'b1) : m;
  endfunction

  function automatic logic [ERR_W-1:0] sat_add(logic [ERR_W-1:0] a, logic [ERR_W-1:0] b);
    logic [ERR_W-1:0] s;
    s = a + b;
    if ((a[ERR_W-1] == b[ERR_W-1]) && (s[ERR_W-1] != a[ERR_W-1])) begin
      s = a[ERR_W-1] ? S64_MIN : S64_MAX;
    end
    return s;
  endfunction

  // item and controller state
  logic [TEMP_W-1:0]  temp_q;
  logic [FREQ_W-1:0]  cur_q;
  logic [TEMP_W-1:0]  last_temp_q;
  logic               have_last_q;
  logic [IW-1:0]      integ_q, integ_d;
  // divider
  logic [POLL_W-1:0]  rem_q, rem_d;
  logic [DIV_W-1:0]   quo_q, quo_d;
  logic               dneg_q;
  // multiplier and accumulator
  logic [PROD_W-1:0]  prod_q, prod_d;
  logic [ACC_W-1:0]   acc_q, acc_d;
  logic               ovf_q, ovf_d;
  logic [ERR_W-1:0]   err_q, err_d;
  logic [SCALE_W-1:0] scale_q, scale_d;

  logic [POLL_W-1:0]  dly;
  logic [TEMP_W:0]    p_s, delta;
  logic               p_neg, d_neg;
  logic [TEMP_W-1:0]  p_mag, d_mag;
  logic [MUL_W-1:0]   mul_a, mul_b;
  logic [PROD_W-1:0]  integ_ext, scale_ext;
  logic [ERR_W-1:0]   err_mag;

  assign dly   = (cfg_i.poll_period == '0) ? POLL_W'(1) : cfg_i.poll_period;
  assign p_s   = {1'b0, temp_q} - {1'b0, cfg_i.target_temp};
  assign p_neg = p_s[TEMP_W];
  assign p_mag = p_neg ? TEMP_W'(~p_s + 1'b1) : p_s[TEMP_W-1:0];

  // first sample forces a zero derivative
  assign delta = have_last_q ? ({1'b0, temperature_i} - {1'b0, last_temp_q}) : '0;
  assign d_neg = delta[TEMP_W];
  assign d_mag = d_neg ? TEMP_W'(~delta + 1'b1) : delta[TEMP_W-1:0];

  assign integ_ext = PROD_W'(integ_q);
  assign scale_ext = PROD_W'(scale_q);
  assign err_mag   = err_q[ERR_W-1] ? (~err_q + 1'b1) : err_q;

  // shared multiplier operand select
  always_comb begin
    unique case (ctl_i.mul)
      MUL_P_DLY:  begin mul_a = MUL_W'(p_mag);           mul_b = MUL_W'(dly); end
      MUL_P_KP:   begin mul_a = MUL_W'(p_mag);           mul_b = gain_mag(cfg_i.gain_prop); end
      MUL_DQ_KD:  begin mul_a = MUL_W'(quo_q);           mul_b = gain_mag(cfg_i.gain_deriv); end
      MUL_I0_KI:  begin mul_a = integ_ext[MUL_W-1:0];    mul_b = gain_mag(cfg_i.gain_integ); end
      MUL_I1_KI:  begin mul_a = integ_ext[PROD_W-1:MUL_W]; mul_b = gain_mag(cfg_i.gain_integ); end
      MUL_KO_DLY: begin mul_a = gain_mag(cfg_i.gain_output); mul_b = MUL_W'(dly); end
      MUL_E0_S0:  begin mul_a = err_mag[MUL_W-1:0];      mul_b = scale_ext[MUL_W-1:0]; end
      MUL_E0_S1:  begin mul_a = err_mag[MUL_W-1:0];      mul_b = scale_ext[PROD_W-1:MUL_W]; end
      MUL_E1_S0:  begin mul_a = err_mag[ERR_W-1:MUL_W];  mul_b = scale_ext[MUL_W-1:0]; end
      MUL_E1_S1:  begin mul_a = err_mag[ERR_W-1:MUL_W];  mul_b = scale_ext[PROD_W-1:MUL_W]; end
      default:    begin mul_a = '0;                      mul_b = '0; end
    endcase
    prod_d = (ctl_i.mul == MUL_NONE) ? prod_q : (PROD_W'(mul_a) * PROD_W'(mul_b));
  end

  // accumulator with sticky overflow, partial products at 0, 32 or 64 bits
  logic [WIDE_W-1:0] acc_wide;
  logic [ACC_W-1:0]  acc_base;
  logic              acc_base_ovf;
  logic [ACC_W:0]    acc_sum;

  always_comb begin
    acc_wide     = '0;
    acc_base     = acc_q;
    acc_base_ovf = ovf_q;
    unique case (ctl_i.acc)
      ACC_HOLD:   acc_wide = '0;
      ACC_LOAD: begin
        acc_wide     = WIDE_W'(prod_q);
        acc_base     = '0;
        acc_base_ovf = 1'b0;
      end
      ACC_ADD_32: acc_wide = WIDE_W'(prod_q) << MUL_W;
      ACC_ADD_64: acc_wide = WIDE_W'(prod_q) << (2 * MUL_W);
    endcase
    acc_sum = {1'b0, acc_base} + {1'b0, acc_wide[ACC_W-1:0]};
    if (ctl_i.acc == ACC_HOLD) begin
      acc_d = acc_q;
      ovf_d = ovf_q;
    end else begin
      acc_d = acc_sum[ACC_W-1:0];
      ovf_d = acc_base_ovf | acc_sum[ACC_W] | (|acc_wide[WIDE_W-1:ACC_W]);
    end
  end

  // divider step, integral update and error terms
  logic [POLL_W:0]   rem_sh;
  logic              div_ge;
  logic [IW:0]       integ_sum;
  logic [IW-1:0]     integ_add;
  logic [ERR_W-1:0]  i_mag;
  logic              i_big;

  assign rem_sh    = {rem_q, quo_q[DIV_W-1]};
  assign div_ge    = rem_sh >= {1'b0, dly};
  assign integ_add = IW'(prod_q[ADD_W-1:0]);
  assign integ_sum = {1'b0, integ_q} + {1'b0, integ_add};
  assign i_big     = ovf_q | (|acc_q[ACC_W-1:ERR_W-1]);
  assign i_mag     = i_big ? S64_MAX : ERR_W'(acc_q[ERR_W-2:0]);

  always_comb begin
    rem_d   = rem_q;
    quo_d   = quo_q;
    integ_d = integ_q;
    err_d   = err_q;
    scale_d = scale_q;
    unique case (ctl_i.op)
      OP_NOP: ;
      OP_DIV_STEP: begin
        rem_d = div_ge ? POLL_W'(rem_sh - {1'b0, dly}) : rem_sh[POLL_W-1:0];
        quo_d = {quo_q[DIV_W-2:0], div_ge};
      end
      OP_INTEG: begin
        if (!p_neg) begin
          integ_d = (integ_sum > {1'b0, IMAX}) ? IMAX : integ_sum[IW-1:0];
        end else begin
          integ_d = (integ_add > integ_q) ? '0 : (integ_q - integ_add);
        end
      end
      OP_ERR_P: err_d = apply_sign(p_neg ^ cfg_i.gain_prop[GAIN_W-1], prod_q);
      OP_ERR_D: err_d = sat_add(err_q,
                          apply_sign(dneg_q ^ cfg_i.gain_deriv[GAIN_W-1], prod_q >> F));
      OP_ERR_I: err_d = sat_add(err_q, apply_sign(cfg_i.gain_integ[GAIN_W-1], i_mag));
      OP_SCALE: scale_d = prod_q[SCALE_W-1:0];
      default: ;
    endcase
  end

  // output scaling: drop 2F fraction bits, cap, subtract and clamp
  logic [HI_W-1:0]         acc_hi;
  logic [MAG_W-1:0]        diff_mag;
  logic                    diff_neg;
  logic signed [TGT_W-1:0] tgt, ceil_ext, floor_ext;

  assign acc_hi    = acc_q[ACC_W-1:2*F];
  assign diff_mag  = (ovf_q || (acc_hi > CAP)) ? CAP[MAG_W-1:0] : acc_hi[MAG_W-1:0];
  assign diff_neg  = err_q[ERR_W-1] ^ cfg_i.gain_output[GAIN_W-1];
  assign tgt       = diff_neg ? (TGT_W'(cur_q) + TGT_W'(diff_mag))
                              : (TGT_W'(cur_q) - TGT_W'(diff_mag));
  assign ceil_ext  = TGT_W'(cfg_i.freq_ceiling);
  assign floor_ext = TGT_W'(cfg_i.freq_floor);

  always_comb begin
    res_o.hit_ceiling    = 1'b0;
    res_o.hit_floor      = 1'b0;
    res_o.overheat_alert = 1'b0;
    priority if (tgt > ceil_ext) begin
      res_o.new_freq    = cfg_i.freq_ceiling;
      res_o.hit_ceiling = 1'b1;
    end else if (tgt < floor_ext) begin
      res_o.new_freq       = cfg_i.freq_floor;
      res_o.hit_floor      = 1'b1;
      res_o.overheat_alert = !p_neg && (p_s != '0);
    end else begin
      res_o.new_freq = tgt[FREQ_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_temp_q <= '0;
      have_last_q <= 1'b0;
      integ_q     <= '0;
    end else begin
      if (start_i) begin
        last_temp_q <= temperature_i;
        have_last_q <= 1'b1;
      end
      integ_q <= integ_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      temp_q <= temperature_i;
      cur_q  <= current_freq_i;
      rem_q  <= '0;
      quo_q  <= {d_mag, {F{1'b0}}};
      dneg_q <= d_neg;
    end else begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
    prod_q  <= prod_d;
    acc_q   <= acc_d;
    ovf_q   <= ovf_d;
    err_q   <= err_d;
    scale_q <= scale_d;
  end

`ifndef SYNTH
  a_integ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    integ_q <= IMAX)
    else $error("integral above its saturation limit");
`endif

endmodule

`default_nettype wire

[rtl/pid_thermal_freq_limiter.sv]
// top level: config registers, handshakes and result register of the limiter
// the program runs its divider loop, then the integral, error and output-scaling steps
// no new sample until the program ends, set by the one-bit-per-step derivative divider
// and the single shared 32x32 multiplier; in_stall_o is high while the program runs
// reset: config registers to their defaults, integral and previous sample cleared,
// first-sample flag pending, no result valid
`default_nettype none

module pid_thermal_freq_limiter (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // configuration write port
  input  logic                              cfg_we_i,
  input  logic [ptfl_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [ptfl_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  // sample channel
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [ptfl_pkg::TEMP_W-1:0]       temperature_i,
  input  logic [ptfl_pkg::FREQ_W-1:0]       current_freq_i,
  // result channel
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [ptfl_pkg::FREQ_W-1:0]       new_freq_o,
  output logic                              hit_ceiling_o,
  output logic                              hit_floor_o,
  output logic                              overheat_alert_o
);
  import ptfl_pkg::*;

  // register defaults
  localparam logic [TEMP_W-1:0] TARGET_RST  = 8'd70;
  localparam logic [POLL_W-1:0] POLL_RST    = 16'd1000;
  localparam logic [FREQ_W-1:0] FLOOR_RST   = 16'd800;
  localparam logic [FREQ_W-1:0] CEILING_RST = 16'd4000;

  // configuration registers; the user must write them only while the block is idle, the block does not enforce it
  logic        [TEMP_W-1:0] target_temp_q;
  logic signed [GAIN_W-1:0] gain_prop_q, gain_integ_q, gain_deriv_q, gain_output_q;
  logic        [POLL_W-1:0] poll_period_q;
  logic        [FREQ_W-1:0] freq_floor_q, freq_ceiling_q;
  cfg_t                     cfg;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_temp_q  <= TARGET_RST;
      gain_prop_q    <= '0;
      gain_integ_q   <= '0;
      gain_deriv_q   <= '0;
      gain_output_q  <= '0;
      poll_period_q  <= POLL_RST;
      freq_floor_q   <= FLOOR_RST;
      freq_ceiling_q <= CEILING_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_TARGET_TEMP:  target_temp_q  <= cfg_wdata_i[TEMP_W-1:0];
        REG_GAIN_PROP:    gain_prop_q    <= cfg_wdata_i[GAIN_W-1:0];
        REG_GAIN_INTEG:   gain_integ_q   <= cfg_wdata_i[GAIN_W-1:0];
        REG_GAIN_DERIV:   gain_deriv_q   <= cfg_wdata_i[GAIN_W-1:0];
        REG_GAIN_OUTPUT:  gain_output_q  <= cfg_wdata_i[GAIN_W-1:0];
        REG_POLL_PERIOD:  poll_period_q  <= cfg_wdata_i[POLL_W-1:0];
        REG_FREQ_FLOOR:   freq_floor_q   <= cfg_wdata_i[FREQ_W-1:0];
        REG_FREQ_CEILING: freq_ceiling_q <= cfg_wdata_i[FREQ_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg.target_temp  = target_temp_q;
  assign cfg.gain_prop    = gain_prop_q;
  assign cfg.gain_integ   = gain_integ_q;
  assign cfg.gain_deriv   = gain_deriv_q;
  assign cfg.gain_output  = gain_output_q;
  assign cfg.poll_period  = poll_period_q;
  assign cfg.freq_floor   = freq_floor_q;
  assign cfg.freq_ceiling = freq_ceiling_q;

  // handshake: a sample transfer starts the program, the last step waits
  // only while a finished result is still held by a stalled receiver
  logic      in_xfer;
  logic      out_hold;
  seq_stat_t seq_stat;
  ctl_t      ctl;
  res_t      res;

  assign in_stall_o = seq_stat.busy;
  assign in_xfer    = in_valid_i && !seq_stat.busy;

  ptfl_seq u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (in_xfer),
    .hold_i  (out_hold),
    .ctl_o   (ctl),
    .stat_o  (seq_stat)
  );

  ptfl_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg),
    .start_i        (in_xfer),
    .temperature_i  (temperature_i),
    .current_freq_i (current_freq_i),
    .ctl_i          (ctl),
    .res_o          (res)
  );

  // result register: the next sample is taken while a result waits here
  logic out_valid_q;
  res_t res_q;

  assign out_hold = out_valid_q && out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (seq_stat.done) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (seq_stat.done) begin
      res_q <= res;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign new_freq_o       = res_q.new_freq;
  assign hit_ceiling_o    = res_q.hit_ceiling;
  assign hit_floor_o      = res_q.hit_floor;
  assign overheat_alert_o = res_q.overheat_alert;

`ifndef SYNTH
  // a sample transfer always starts a program run
  a_xfer_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> seq_stat.busy)
    else $error("sample taken but sequencer not running");

  // a result appears only at the end of a program run
  a_valid_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(seq_stat.done))
    else $error("result valid without a finished run");

  // a ceiling hit always reports the ceiling itself
  a_ceiling_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && res_q.hit_ceiling) |-> (res_q.new_freq == freq_ceiling_q))
    else $error("ceiling flag with wrong frequency");

  // floor and ceiling flags never together, alert only with a floor hit
  a_flags_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (!(res_q.hit_ceiling && res_q.hit_floor)
                     && !(res_q.overheat_alert && !res_q.hit_floor)))
    else $error("inconsistent clamp flags");
`endif

endmodule

`default_nettype wire

[bench/tb.sv]
// self-checking testbench for the pid thermal frequency limiter
`timescale 1ns / 1ps

module tb;
  import ptfl_pkg::*;

  localparam int unsigned HALF_PERIOD  = 6;
  // quiet time before a register write, a little over one program run
  localparam int unsigned DRAIN_CYCLES = 45;
  // long receiver hold-off so the single result slot fills and the input stalls
  localparam int unsigned HOLD_CYCLES  = 600;
  localparam int unsigned PHASE_ITEMS  = 75;
  localparam int unsigned N_PHASES     = 6;
  localparam int unsigned HOLD_PHASE   = 4;
  localparam int unsigned MAX_REPORTS  = 10;
  // slowest correct run is a few hundred microseconds
  localparam int unsigned LIMIT_NS     = 4_000_000;

  localparam longint unsigned DIFF_CAP  = 64'd1 << 40;
  localparam longint unsigned INTEG_MAX = (64'd1 << (INTEGRAL_WIDTH - 1)) - 1;
  localparam longint          S64_MAX   = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam longint          S64_MIN   = 64'h8000_0000_0000_0000;

  // one line of the directed plan: either a register write or a sample transfer
  typedef struct {
    bit                    is_cfg;
    cfg_reg_e              idx;
    logic [CFG_DATA_W-1:0] data;
    logic [TEMP_W-1:0]     temp;
    logic [FREQ_W-1:0]     cur;
    bit                    typed;
    res_t                  want;
  } plan_row_t;

  // dut ports
  logic                  clk_i          = 1'b0;
  logic                  rst_ni         = 1'b0;
  logic                  cfg_we_i       = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i      = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i    = '0;
  logic                  in_valid_i     = 1'b0;
  logic                  in_stall_o;
  logic [TEMP_W-1:0]     temperature_i  = '0;
  logic [FREQ_W-1:0]     current_freq_i = '0;
  logic                  out_valid_o;
  logic                  out_stall_i    = 1'b0;
  logic [FREQ_W-1:0]     new_freq_o;
  logic                  hit_ceiling_o;
  logic                  hit_floor_o;
  logic                  overheat_alert_o;

  // shadow of the register file and of the controller state
  cfg_t                  lim_cfg;
  logic [TEMP_W-1:0]     prev_temp;
  bit                    have_prev;
  longint unsigned       integ_sum;

  // limits still owed by the block, oldest first
  res_t                  pending_limits[$];
  logic [FREQ_W-1:0]     last_freq;
  int unsigned           fail_cnt      = 0;
  int unsigned           send_idle_pct = 0;
  int unsigned           stall_pct     = 0;
  logic                  holding       = 1'b0;

  pid_thermal_freq_limiter dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .temperature_i    (temperature_i),
    .current_freq_i   (current_freq_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .new_freq_o       (new_freq_o),
    .hit_ceiling_o    (hit_ceiling_o),
    .hit_floor_o      (hit_floor_o),
    .overheat_alert_o (overheat_alert_o)
  );

  always #(HALF_PERIOD) clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // predictor arithmetic, sign-magnitude with 64-bit saturation
  // ---------------------------------------------------------------------------

  function automatic longint unsigned magnitude(longint v);
    return (v < 0) ? 64'(-v) : 64'(v);
  endfunction

  function automatic longint apply_sign(bit neg, longint unsigned m);
    return neg ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint mul_sat(longint a, longint b);
    logic [127:0] prod;
    prod = {64'd0, magnitude(a)} * {64'd0, magnitude(b)};
    if (prod > 128'(S64_MAX)) begin
      prod = 128'(S64_MAX);
    end
    return apply_sign((a < 0) != (b < 0), prod[63:0]);
  endfunction

  function automatic longint add_sat(longint a, longint b);
    logic [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) begin
      return s[64] ? S64_MIN : S64_MAX;
    end
    return longint'(s[63:0]);
  endfunction

  // next frequency limit for one sample; updates the shadow controller state
  function automatic res_t calc_new_limit(logic [TEMP_W-1:0] temp, logic [FREQ_W-1:0] cur);
    longint unsigned dly, add, scale;
    longint          kp, ki, kd, ko;
    longint          p, delta, dq, dterm, err, diff, target;
    logic [127:0]    wide;
    res_t            r;
    kp  = longint'($signed(lim_cfg.gain_prop));
    ki  = longint'($signed(lim_cfg.gain_integ));
    kd  = longint'($signed(lim_cfg.gain_deriv));
    ko  = longint'($signed(lim_cfg.gain_output));
    // a zero polling period counts as one
    dly = (lim_cfg.poll_period == 0) ? 64'd1 : 64'(lim_cfg.poll_period);
    p   = longint'(temp) - longint'(lim_cfg.target_temp);
    // no previous sample yet: derivative forced to zero
    if (!have_prev) begin
      prev_temp = temp;
    end
    delta     = longint'(temp) - longint'(prev_temp);
    dq        = apply_sign(delta < 0, (magnitude(delta) << GAIN_FRAC_BITS) / dly);
    prev_temp = temp;
    have_prev = 1'b1;
    // integral clamps at zero below and saturates above
    add = magnitude(p) * dly;
    if (p >= 0) begin
      integ_sum = (integ_sum > INTEG_MAX - add) ? INTEG_MAX : integ_sum + add;
    end else begin
      integ_sum = (add > integ_sum) ? 64'd0 : integ_sum - add;
    end
    err   = mul_sat(p, kp);
    dterm = mul_sat(dq, kd);
    err   = add_sat(err, apply_sign(dterm < 0, magnitude(dterm) >> GAIN_FRAC_BITS));
    err   = add_sat(err, mul_sat(longint'(integ_sum), ki));
    // output scaling, back to whole MHz, magnitude capped
    scale  = magnitude(ko) * dly;
    wide   = ({64'd0, magnitude(err)} * {64'd0, scale}) >> (2 * GAIN_FRAC_BITS);
    diff   = apply_sign((err < 0) != (ko < 0),
                        (wide > {64'd0, DIFF_CAP}) ? DIFF_CAP : wide[63:0]);
    target = longint'(cur) - diff;
    r = '0;
    // ceiling is tested first: a target above both bounds yields the ceiling
    if (target > longint'(lim_cfg.freq_ceiling)) begin
      r.new_freq    = lim_cfg.freq_ceiling;
      r.hit_ceiling = 1'b1;
    end else if (target < longint'(lim_cfg.freq_floor)) begin
      r.new_freq       = lim_cfg.freq_floor;
      r.hit_floor      = 1'b1;
      r.overheat_alert = (p > 0);
    end else begin
      r.new_freq = target[FREQ_W-1:0];
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // directed plan rows
  // ---------------------------------------------------------------------------

  function automatic plan_row_t reg_row(cfg_reg_e idx, logic [CFG_DATA_W-1:0] data);
    plan_row_t r;
    r = '{is_cfg: 1'b1, idx: idx, data: data, temp: '0, cur: '0, typed: 1'b0, want: '0};
    return r;
  endfunction

  function automatic plan_row_t sample_row(logic [TEMP_W-1:0] temp, logic [FREQ_W-1:0] cur);
    plan_row_t r;
    r = '{is_cfg: 1'b0, idx: REG_TARGET_TEMP, data: '0, temp: temp, cur: cur,
          typed: 1'b0, want: '0};
    return r;
  endfunction

  function automatic plan_row_t known_row(logic [TEMP_W-1:0] temp, logic [FREQ_W-1:0] cur,
                                          logic [FREQ_W-1:0] nf, logic hc, logic hf,
                                          logic oh);
    plan_row_t r;
    r       = sample_row(temp, cur);
    r.typed = 1'b1;
    r.want  = '{new_freq: nf, hit_ceiling: hc, hit_floor: hf, overheat_alert: oh};
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  // random junk above a narrow register field
  function automatic logic [CFG_DATA_W-1:0] pad(int unsigned w, logic [CFG_DATA_W-1:0] v);
    return ($urandom << w) | v;
  endfunction

  // mostly modest gains, now and then any 32-bit value
  function automatic logic [CFG_DATA_W-1:0] rand_gain(int unsigned span);
    logic [CFG_DATA_W-1:0] g;
    case ($urandom_range(9))
      0:       g = $urandom;
      1:       g = '0;
      default: g = $urandom_range(span);
    endcase
    if ($urandom_range(1) == 1) begin
      g = -g;
    end
    return g;
  endfunction

  task automatic write_reg(cfg_reg_e idx, logic [CFG_DATA_W-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    case (idx)
      REG_TARGET_TEMP:  lim_cfg.target_temp  = data[TEMP_W-1:0];
      REG_GAIN_PROP:    lim_cfg.gain_prop    = data;
      REG_GAIN_INTEG:   lim_cfg.gain_integ   = data;
      REG_GAIN_DERIV:   lim_cfg.gain_deriv   = data;
      REG_GAIN_OUTPUT:  lim_cfg.gain_output  = data;
      REG_POLL_PERIOD:  lim_cfg.poll_period  = data[POLL_W-1:0];
      REG_FREQ_FLOOR:   lim_cfg.freq_floor   = data[FREQ_W-1:0];
      REG_FREQ_CEILING: lim_cfg.freq_ceiling = data[FREQ_W-1:0];
      default: ;
    endcase
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // offer one sample, with random idle cycles first; returns after the transfer
  task automatic send_sample(logic [TEMP_W-1:0] temp, logic [FREQ_W-1:0] cur, bit typed,
                             res_t want);
    res_t predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i     <= 1'b0;
      temperature_i  <= $urandom;
      current_freq_i <= $urandom;
      @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    temperature_i  <= temp;
    current_freq_i <= cur;
    @(posedge clk_i);
    while (in_stall_o) begin
      @(posedge clk_i);
    end
    // the predictor always runs so its state follows the block
    predicted = calc_new_limit(temp, cur);
    last_freq = predicted.new_freq;
    pending_limits.push_back(typed ? want : predicted);
  endtask

  // block is idle once every owed limit has come back and the pipe has emptied
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (pending_limits.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // result side: random stall, compare each transfer against the oldest limit
  // ---------------------------------------------------------------------------

  always @(posedge clk_i) begin : result_check
    res_t want;
    res_t got;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = {new_freq_o, hit_ceiling_o, hit_floor_o, overheat_alert_o};
      if (pending_limits.size() == 0) begin
        if (fail_cnt < MAX_REPORTS) begin
          $display("unexpected result at %0t ns: new_freq %0d", $time, new_freq_o);
        end
        fail_cnt++;
      end else begin
        want = pending_limits.pop_front();
        if (got !== want) begin
          if (fail_cnt < MAX_REPORTS) begin
            $display("mismatch at %0t ns (exp/got): new_freq %0d/%0d ceil %0b/%0b floor %0b/%0b alert %0b/%0b",
                     $time, want.new_freq, got.new_freq, want.hit_ceiling, got.hit_ceiling,
                     want.hit_floor, got.hit_floor, want.overheat_alert, got.overheat_alert);
          end
          fail_cnt++;
        end
      end
    end
    out_stall_i <= holding || ($urandom_range(99) < stall_pct);
  end

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------

  initial begin : stimulus
    plan_row_t   plan[$];
    bit          sent;
    int          t;
    int          f;
    int unsigned fl;
    int unsigned cl;
    int unsigned pl;
    int unsigned walk_temp;

    lim_cfg              = '0;
    lim_cfg.target_temp  = 8'd70;
    lim_cfg.poll_period  = 16'd1000;
    lim_cfg.freq_floor   = 16'd800;
    lim_cfg.freq_ceiling = 16'd4000;
    prev_temp            = '0;
    have_prev            = 1'b0;
    integ_sum            = 0;
    last_freq            = 16'd2000;
    sent                 = 1'b0;
    walk_temp            = 70;

    // reset values, all gains zero: output is just the clamped input frequency
    plan.push_back(known_row(8'd0,   16'd0,     16'd800,   1'b0, 1'b1, 1'b0)); // first sample
    plan.push_back(known_row(8'd255, 16'hFFFF,  16'd4000,  1'b1, 1'b0, 1'b0));
    plan.push_back(known_row(8'd255, 16'd0,     16'd800,   1'b0, 1'b1, 1'b1));
    plan.push_back(known_row(8'd70,  16'd2000,  16'd2000,  1'b0, 1'b0, 1'b0));
    plan.push_back(known_row(8'd71,  16'd4000,  16'd4000,  1'b0, 1'b0, 1'b0));
    plan.push_back(known_row(8'd100, 16'd800,   16'd800,   1'b0, 1'b0, 1'b0));
    // floor set above the ceiling
    plan.push_back(reg_row(REG_FREQ_FLOOR,   32'd3000));
    plan.push_back(reg_row(REG_FREQ_CEILING, 32'd1000));
    plan.push_back(known_row(8'd80,  16'd2000,  16'd1000,  1'b1, 1'b0, 1'b0));
    plan.push_back(known_row(8'd80,  16'd500,   16'd3000,  1'b0, 1'b1, 1'b1));
    plan.push_back(known_row(8'd60,  16'd1000,  16'd3000,  1'b0, 1'b1, 1'b0));
    // extreme gains drive the correction into its cap
    plan.push_back(reg_row(REG_FREQ_FLOOR,   32'd0));
    plan.push_back(reg_row(REG_FREQ_CEILING, 32'hFFFF));
    plan.push_back(reg_row(REG_TARGET_TEMP,  32'd0));
    plan.push_back(reg_row(REG_GAIN_PROP,    32'h7FFF_FFFF));
    plan.push_back(reg_row(REG_GAIN_OUTPUT,  32'h7FFF_FFFF));
    plan.push_back(known_row(8'd255, 16'hFFFF,  16'd0,     1'b0, 1'b1, 1'b1));
    plan.push_back(reg_row(REG_GAIN_PROP,    32'h8000_0000));
    plan.push_back(known_row(8'd255, 16'd0,     16'hFFFF,  1'b1, 1'b0, 1'b0));
    plan.push_back(reg_row(REG_TARGET_TEMP,  32'd255));
    plan.push_back(known_row(8'd0,   16'hFFFF,  16'd0,     1'b0, 1'b1, 1'b0));
    plan.push_back(reg_row(REG_TARGET_TEMP,  32'd0));
    plan.push_back(reg_row(REG_GAIN_PROP,    32'h7FFF_FFFF));
    plan.push_back(reg_row(REG_GAIN_OUTPUT,  32'h8000_0000));
    plan.push_back(known_row(8'd255, 16'd0,     16'hFFFF,  1'b1, 1'b0, 1'b0));
    // moderate gains with a zero polling period
    plan.push_back(reg_row(REG_TARGET_TEMP,  32'd70));
    plan.push_back(reg_row(REG_GAIN_PROP,    32'h0001_0000));
    plan.push_back(reg_row(REG_GAIN_INTEG,   32'h0000_0020));
    plan.push_back(reg_row(REG_GAIN_DERIV,   32'h0002_0000));
    plan.push_back(reg_row(REG_GAIN_OUTPUT,  32'h0000_0040));
    plan.push_back(reg_row(REG_POLL_PERIOD,  32'd0));
    plan.push_back(reg_row(REG_FREQ_FLOOR,   32'd800));
    plan.push_back(reg_row(REG_FREQ_CEILING, 32'd4000));
    plan.push_back(sample_row(8'd90,  16'd2000));
    plan.push_back(sample_row(8'd40,  16'd2000));
    plan.push_back(sample_row(8'd40,  16'd2500));
    plan.push_back(sample_row(8'd200, 16'd3000));
    // longest polling period, negative gains
    plan.push_back(reg_row(REG_POLL_PERIOD,  32'hFFFF));
    plan.push_back(reg_row(REG_GAIN_DERIV,   32'hFFFE_0000));
    plan.push_back(reg_row(REG_GAIN_INTEG,   32'hFFFF_FFFF));
    plan.push_back(reg_row(REG_GAIN_OUTPUT,  32'hFFFF_FFC0));
    plan.push_back(sample_row(8'd75,  16'd1500));
    plan.push_back(sample_row(8'd20,  16'd3900));
    plan.push_back(sample_row(8'd255, 16'hFFFF));
    plan.push_back(sample_row(8'd0,   16'd0));
    // derivative and integral gains at their extremes, one-millisecond period
    plan.push_back(reg_row(REG_POLL_PERIOD,  32'd1));
    plan.push_back(reg_row(REG_GAIN_DERIV,   32'h8000_0000));
    plan.push_back(reg_row(REG_GAIN_INTEG,   32'h7FFF_FFFF));
    plan.push_back(sample_row(8'd0,   16'd1000));
    plan.push_back(sample_row(8'd255, 16'd1000));

    // reset held, then released on an edge
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part, no idling
    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        if (sent) begin
          wait_idle();
          sent = 1'b0;
        end
        write_reg(plan[i].idx, plan[i].data);
      end else begin
        send_sample(plan[i].temp, plan[i].cur, plan[i].typed, plan[i].want);
        sent = 1'b1;
      end
    end

    // random part: a fresh register setting per phase, idle profile rotates
    for (int ph = 0; ph < N_PHASES; ph++) begin
      wait_idle();
      write_reg(REG_TARGET_TEMP, pad(TEMP_W, ($urandom_range(4) == 0) ?
                                     $urandom_range(255) : $urandom_range(40, 100)));
      write_reg(REG_GAIN_PROP,   rand_gain(32'h0004_0000));
      write_reg(REG_GAIN_INTEG,  rand_gain(32'h0000_0100));
      write_reg(REG_GAIN_DERIV,  rand_gain(32'h0004_0000));
      write_reg(REG_GAIN_OUTPUT, rand_gain(32'h0000_0400));
      case ($urandom_range(7))
        0:       pl = 0;
        1:       pl = 1;
        2:       pl = 16'hFFFF;
        default: pl = $urandom_range(1, 2000);
      endcase
      write_reg(REG_POLL_PERIOD, pad(POLL_W, pl));
      if ($urandom_range(4) == 0) begin
        fl = $urandom_range(16'hFFFF);
        cl = $urandom_range(16'hFFFF);
      end else begin
        fl = $urandom_range(200, 1500);
        cl = $urandom_range(2000, 5000);
      end
      write_reg(REG_FREQ_FLOOR,   pad(FREQ_W, fl));
      write_reg(REG_FREQ_CEILING, pad(FREQ_W, cl));

      case (ph % 4)
        0: begin
          send_idle_pct = 0;
          stall_pct     = 0;
        end
        1: begin
          send_idle_pct = 45;
          stall_pct     = 0;
        end
        2: begin
          send_idle_pct = 0;
          stall_pct     = 45;
        end
        default: begin
          send_idle_pct = 25;
          stall_pct     = 25;
        end
      endcase

      // long hold-off on the result side while samples keep coming
      if (ph == HOLD_PHASE) begin
        fork
          begin
            holding <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clk_i);
            holding <= 1'b0;
          end
        join_none
      end

      repeat (PHASE_ITEMS) begin
        // temperature: mostly a slow drift or near the setpoint, some anywhere
        case ($urandom_range(9))
          0, 1:    t = $urandom_range(255);
          2, 3, 4: t = int'(lim_cfg.target_temp) + int'($urandom_range(60)) - 30;
          default: t = int'(walk_temp) + int'($urandom_range(10)) - 5;
        endcase
        if (t < 0) begin
          t = 0;
        end else if (t > 255) begin
          t = 255;
        end
        walk_temp = t;
        // frequency: mostly fed back from the last limit, some in range, some anywhere
        case ($urandom_range(9))
          0, 1:    f = $urandom_range(16'hFFFF);
          2, 3, 4: f = $urandom_range(lim_cfg.freq_floor, lim_cfg.freq_ceiling);
          default: f = int'(last_freq) + int'($urandom_range(200)) - 100;
        endcase
        if (f < 0) begin
          f = 0;
        end else if (f > 65535) begin
          f = 65535;
        end
        send_sample(t[TEMP_W-1:0], f[FREQ_W-1:0], 1'b0, '0);
      end
    end

    wait_idle();
    if (fail_cnt == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #(LIMIT_NS);
    $display("tb failed");
    $finish;
  end

endmodule

[sim.f]
rtl/ptfl_pkg.sv
rtl/ptfl_seq.sv
rtl/ptfl_dp.sv
rtl/pid_thermal_freq_limiter.sv
bench/tb.sv
